>>> sv/skq_pkg.sv
// Shared types and codes for the sorted key table queue.
// No dependencies; imported by skq_cell and the top level.
`timescale 1ns / 1ps
`default_nettype none
package skq_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_POP    = 2'd1,
      OP_UPDATE = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // contents of one table cell
   typedef struct packed {
      logic               valid;
      logic [63:0]        key;
      logic signed [31:0] budget;
      logic signed [31:0] spent;
   } cell_state_type;

   // command broadcast to every cell
   typedef struct packed {
      logic               insert;
      logic               pop;
      logic               update;
      logic [63:0]        key;
      logic signed [31:0] amount;
   } cmd_type;

   localparam logic signed [31:0] SPENT_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] SPENT_MIN = 32'sh8000_0000;

endpackage
`default_nettype wire

>>> sv/skq_cell.sv
// One cell of the sorted chain: holds an entry, shifts to its neighbors.
// Depends on skq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module skq_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire skq_pkg::cmd_type        cmd,
   input  wire skq_pkg::cell_state_type left_state,
   input  wire logic                    left_pos,
   input  wire skq_pkg::cell_state_type right_state,
   input  wire logic                    right_match,
   output skq_pkg::cell_state_type      state,
   output logic                         pos,
   output logic                         match
);
   import skq_pkg::*;

   cell_state_type     st_ff, st_in;
   logic signed [32:0] sum;
   logic signed [31:0] sat;

   assign state = st_ff;

   // insert point, key match and saturated spent total
   always_comb begin
      pos   = !st_ff.valid || (st_ff.key >= cmd.key);
      match = st_ff.valid && (st_ff.key == cmd.key);
      sum   = {st_ff.spent[31], st_ff.spent} + {cmd.amount[31], cmd.amount};
      if (sum > 33'(SPENT_MAX))      sat = SPENT_MAX;
      else if (sum < 33'(SPENT_MIN)) sat = SPENT_MIN;
      else                           sat = sum[31:0];
   end

   // next cell contents
   always_comb begin
      st_in = st_ff;
      if (cmd.insert) begin
         if (pos) begin
            if (left_pos) begin
               st_in = left_state;
            end else begin
               st_in.valid  = 1'b1;
               st_in.key    = cmd.key;
               st_in.budget = cmd.amount;
               st_in.spent  = '0;
            end
         end
      end else if (cmd.pop) begin
         st_in = right_state;
      end else if (cmd.update && match && !right_match) begin
         // oldest of the equal keys sits furthest from the tail
         st_in.spent = sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.valid <= 1'b0;
      end else begin
         st_ff <= st_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/sorted_key_table_queue_unit.sv
// Top level of the sorted key table queue: chain of skq_cell and response register.
// Depends on skq_pkg and skq_cell.
`timescale 1ns / 1ps
`default_nettype none
// The table is a row of ENTRIES cells kept in ascending key order, cell 0
// holding the smallest key (the tail of the list). Each request is applied when
// it is taken: an insert shifts the cells above its slot up by one, a pop
// shifts every cell down by one, and an update adds to the matching cell that
// is oldest among equal keys, with spent saturating at 32 bits. The response
// is registered and appears in the cycle after the request is taken, and a
// new request is taken in that same cycle unless a response is stalled. The
// whole table is compared against the key in parallel, so the path through the
// 64-bit compares and the match reduction over all cells sets the clock.
module sorted_key_table_queue_unit #(
   parameter int ENTRIES = 128
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_opcode,
   input  wire logic [63:0]        req_key,
   input  wire logic signed [31:0] req_amount,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [63:0]             rsp_key_out,
   output logic signed [31:0]      rsp_budget_out,
   output logic signed [31:0]      rsp_spent_out
);
   import skq_pkg::*;

   cell_state_type cells [ENTRIES];
   logic [ENTRIES-1:0] pos;
   logic [ENTRIES-1:0] match;
   cmd_type            cmd;
   logic               accept, full, empty;
   opcode_type         op;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   logic [63:0]        key_ff, key_in;
   logic signed [31:0] budget_ff, budget_in, spent_ff, spent_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign op        = opcode_type'(req_opcode);
   assign full      = cells[ENTRIES-1].valid;
   assign empty     = !cells[0].valid;

   // command to the chain
   always_comb begin
      cmd.insert = accept && (op == OP_INSERT) && !full;
      cmd.pop    = accept && (op == OP_POP);
      cmd.update = accept && (op == OP_UPDATE);
      cmd.key    = req_key;
      cmd.amount = req_amount;
   end

   // cell chain
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      cell_state_type ls, rs;
      logic           lp, rm;
      if (i == 0) begin : g_first
         assign ls = '0;
         assign lp = 1'b0;
      end else begin : g_mid
         assign ls = cells[i-1];
         assign lp = pos[i-1];
      end
      if (i == ENTRIES-1) begin : g_last
         assign rs = '0;
         assign rm = 1'b0;
      end else begin : g_inner
         assign rs = cells[i+1];
         assign rm = match[i+1];
      end
      skq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_state  (ls),
         .left_pos    (lp),
         .right_state (rs),
         .right_match (rm),
         .state       (cells[i]),
         .pos         (pos[i]),
         .match       (match[i])
      );
   end

   // response for the request being taken
   always_comb begin
      status_in = ST_OK;
      key_in    = '0;
      budget_in = '0;
      spent_in  = '0;
      unique case (op)
         OP_INSERT: if (full) status_in = ST_FULL;
         OP_POP: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               key_in    = cells[0].key;
               budget_in = cells[0].budget;
               spent_in  = cells[0].spent;
            end
         end
         OP_UPDATE: if (!(|match)) status_in = ST_NOT_FOUND;
         default: status_in = ST_OK;
      endcase
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept)                         rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         status_ff <= status_in;
         key_ff    <= key_in;
         budget_ff <= budget_in;
         spent_ff  <= spent_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_key_out    = key_ff;
   assign rsp_budget_out = budget_ff;
   assign rsp_spent_out  = spent_ff;

endmodule
`default_nettype wire
